### sv/pcrp_pkg.sv
`default_nettype none
package pcrp_pkg;

  localparam int OUT_PORTS     = 16;
  localparam int MAX_ROUTE_LEN = 16;
  localparam int PLAN_CHANNELS = 16;

  localparam int OUT_W  = $clog2(OUT_PORTS);
  localparam int POS_W  = $clog2(MAX_ROUTE_LEN);
  localparam int LEN_W  = POS_W + 1;
  localparam int ADDR_W = OUT_W + POS_W;
  localparam int CH_W   = 4;
  localparam int CNT_W  = 5;

  typedef enum logic [2:0] {
    CMD_QUERY  = 3'd0,
    CMD_APPEND = 3'd1,
    CMD_SET    = 3'd2,
    CMD_TRUNC  = 3'd3,
    CMD_IDENT  = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_SINGLE    = 2'd0,
    MODE_DYN_BELOW = 2'd1,
    MODE_DYN_ABOVE = 2'd2,
    MODE_CUSTOM    = 2'd3
  } mode_t;

  // Program steps; numbering matters, fall-through goes to step + 1.
  typedef enum logic [3:0] {
    P_IDLE       = 4'd0,
    P_RANGE      = 4'd1,
    P_EMIT_RANGE = 4'd2,
    P_CUSTOM     = 4'd3,
    P_EMIT_CUST  = 4'd4,
    P_EMPTY      = 4'd5,
    P_APPEND     = 4'd6,
    P_SET        = 4'd7,
    P_TRUNC      = 4'd8,
    P_IDENT      = 4'd9
  } step_t;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_CALC,
    OP_EMIT_RANGE,
    OP_CUST_START,
    OP_EMIT_CUST,
    OP_EMIT_EMPTY,
    OP_APPEND,
    OP_SET,
    OP_TRUNC,
    OP_IDENT
  } op_t;

  typedef enum logic [2:0] {
    C_NEXT,
    C_JUMP,
    C_DISPATCH,
    C_IF_EMPTY,
    C_IF_LENZ,
    C_EMIT
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } uword_t;

  typedef struct packed {
    op_t   op;
    logic  accept;
    mode_t mode;
  } ctrl_t;

  typedef struct packed {
    logic adv;
    logic last;
    logic empty;
    logic len_zero;
  } stat_t;

  typedef struct packed {
    logic [OUT_W-1:0] idx;
    logic [POS_W-1:0] pos;
    logic [CH_W-1:0]  src;
  } edit_t;

  typedef struct packed {
    logic [3:0]      dest_output;
    logic [3:0]      slot;
    logic [CH_W-1:0] source_channel;
    logic            silent;
    logic            empty_res;
    logic            last;
  } res_t;

  function automatic uword_t ucode(input step_t pc);
    uword_t w;
    case (pc)
      P_IDLE:       w = '{OP_IDLE,       C_DISPATCH, P_IDLE};
      P_RANGE:      w = '{OP_CALC,       C_IF_EMPTY, P_EMPTY};
      P_EMIT_RANGE: w = '{OP_EMIT_RANGE, C_EMIT,     P_IDLE};
      P_CUSTOM:     w = '{OP_CUST_START, C_IF_LENZ,  P_EMPTY};
      P_EMIT_CUST:  w = '{OP_EMIT_CUST,  C_EMIT,     P_IDLE};
      P_EMPTY:      w = '{OP_EMIT_EMPTY, C_EMIT,     P_IDLE};
      P_APPEND:     w = '{OP_APPEND,     C_JUMP,     P_IDLE};
      P_SET:        w = '{OP_SET,        C_JUMP,     P_IDLE};
      P_TRUNC:      w = '{OP_TRUNC,      C_JUMP,     P_IDLE};
      P_IDENT:      w = '{OP_IDENT,      C_JUMP,     P_IDLE};
      default:      w = '{OP_IDLE,       C_JUMP,     P_IDLE};
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

### sv/pcrp_ifs.sv
`default_nettype none
interface pcrp_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [3:0]  output_index;
  logic [15:0] connected_mask;
  logic [4:0]  channel_count;
  logic [3:0]  position;
  logic [3:0]  src;

  modport source (output valid, command, output_index, connected_mask, channel_count,
                  position, src, input ready);
  modport sink (input valid, command, output_index, connected_mask, channel_count,
                position, src, output ready);
endinterface

interface pcrp_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] dest_output;
  logic [3:0] slot;
  logic [3:0] source_channel;
  logic       silent;
  logic       empty_res;
  logic       last;

  modport source (output valid, dest_output, slot, source_channel, silent, empty_res, last,
                  input ready);
  modport sink (input valid, dest_output, slot, source_channel, silent, empty_res, last,
                output ready);
endinterface

interface pcrp_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] routing_mode;

  modport source (output valid, routing_mode, input ready);
  modport sink (input valid, routing_mode, output ready);
endinterface
`default_nettype wire

### sv/poly_channel_route_planner.sv
`default_nettype none
// Polyphonic channel route planner. A query transfer names an output, a mask of
// connected outputs and the input channel count; the block answers with one
// result transfer per routed slot of that output (last marks the final one),
// or a single empty_res result when the output carries nothing. Edit transfers
// (append, set, truncate, reset to identity) change the custom lists and give
// no result. Flow: an item is taken in the sequencer's idle step; a query
// then passes through range or list setup and the emit loop, which gives
// one result per cycle and stalls with the output register; an edit runs
// its own edit step and then returns to the idle step.
// The custom lists sit in a 256 x 4 memory with a registered read port; the
// identity value of each list's first entry is held by a per-list flag, so
// reset takes effect at once with no clearing pass. routing_mode (reset:
// dynamic below) is written through the cfg channel, which is always ready.
module poly_channel_route_planner (
  input  logic       clk,
  input  logic       rst_n,
  pcrp_in_if.sink    in_if,
  pcrp_out_if.source out_if,
  pcrp_cfg_if.sink   cfg_if
);
  import pcrp_pkg::*;

  ctrl_t               ctrl;
  stat_t               stat;
  edit_t               req;
  logic [ADDR_W-1:0]   rd_addr;
  logic [CH_W-1:0]     rd_data;
  logic [LEN_W-1:0]    len_sel;
  logic                head_valid;
  logic                in_ready;

  // the user must let config writes arrive only while idle (not enforced by the block); they are always taken
  assign cfg_if.ready = 1'b1;
  assign in_if.ready  = in_ready;

  // step counter plus control-word table; owns the input handshake
  pcrp_sequencer u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_if.valid),
    .in_command (in_if.command),
    .cfg_valid  (cfg_if.valid),
    .cfg_mode   (cfg_if.routing_mode),
    .stat       (stat),
    .in_ready   (in_ready),
    .ctrl       (ctrl)
  );

  // latched query fields, range planner and the result register
  pcrp_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .ctrl              (ctrl),
    .in_output_index   (in_if.output_index),
    .in_connected_mask (in_if.connected_mask),
    .in_channel_count  (in_if.channel_count),
    .in_position       (in_if.position),
    .in_source         (in_if.src),
    .rd_data           (rd_data),
    .len_sel           (len_sel),
    .head_valid        (head_valid),
    .req               (req),
    .rd_addr           (rd_addr),
    .stat              (stat),
    .out_if            (out_if)
  );

  // custom list entries and lengths
  pcrp_route_store u_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .op         (ctrl.op),
    .req        (req),
    .rd_addr    (rd_addr),
    .rd_data_r  (rd_data),
    .len_sel    (len_sel),
    .head_valid (head_valid)
  );

endmodule
`default_nettype wire

### sv/pcrp_sequencer.sv
`default_nettype none
module pcrp_sequencer (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic [2:0]     in_command,
  input  logic           cfg_valid,
  input  logic [1:0]     cfg_mode,
  input  pcrp_pkg::stat_t stat,
  output logic           in_ready,
  output pcrp_pkg::ctrl_t ctrl
);
  import pcrp_pkg::*;

  step_t  pc_r, pc_nxt;
  mode_t  mode_r;
  uword_t uw;
  step_t  dispatch;
  logic   accept;

  assign uw       = ucode(pc_r);
  assign in_ready = (uw.cond == C_DISPATCH);
  assign accept   = in_valid && in_ready;

  always_comb begin
    case (cmd_t'(in_command))
      CMD_QUERY:  dispatch = (mode_r == MODE_CUSTOM) ? P_CUSTOM : P_RANGE;
      CMD_APPEND: dispatch = P_APPEND;
      CMD_SET:    dispatch = P_SET;
      CMD_TRUNC:  dispatch = P_TRUNC;
      CMD_IDENT:  dispatch = P_IDENT;
      default:    dispatch = P_IDLE;
    endcase
  end

  // next step
  always_comb begin
    case (uw.cond)
      C_NEXT:     pc_nxt = step_t'(pc_r + 4'd1);
      C_JUMP:     pc_nxt = uw.target;
      C_DISPATCH: pc_nxt = accept ? dispatch : pc_r;
      C_IF_EMPTY: pc_nxt = stat.empty ? uw.target : step_t'(pc_r + 4'd1);
      C_IF_LENZ:  pc_nxt = stat.len_zero ? uw.target : step_t'(pc_r + 4'd1);
      C_EMIT:     pc_nxt = (stat.adv && stat.last) ? uw.target : pc_r;
      default:    pc_nxt = P_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    ctrl.op     = uw.op;
    ctrl.accept = accept;
    ctrl.mode   = mode_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r   <= P_IDLE;
      mode_r <= MODE_DYN_BELOW;
    end else begin
      pc_r <= pc_nxt;
      if (cfg_valid) mode_r <= mode_t'(cfg_mode);
    end
  end

endmodule
`default_nettype wire

### sv/pcrp_route_store.sv
`default_nettype none
module pcrp_route_store (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pcrp_pkg::op_t                 op,
  input  pcrp_pkg::edit_t               req,
  input  logic [pcrp_pkg::ADDR_W-1:0]   rd_addr,
  output logic [pcrp_pkg::CH_W-1:0]     rd_data_r,
  output logic [pcrp_pkg::LEN_W-1:0]    len_sel,
  output logic                          head_valid
);
  import pcrp_pkg::*;

  logic [CH_W-1:0]   mem [OUT_PORTS*MAX_ROUTE_LEN];
  logic [LEN_W-1:0]  len_r [OUT_PORTS];
  logic [LEN_W-1:0]  len_nxt;
  // entry zero of a list reads as its identity value until written
  logic [OUT_PORTS-1:0] head_r, head_nxt;
  logic              we;
  logic [POS_W-1:0]  wpos;

  assign len_sel    = len_r[req.idx];
  assign head_valid = head_r[req.idx];

  always_comb begin
    we       = 1'b0;
    wpos     = req.pos;
    len_nxt  = len_sel;
    head_nxt = head_r;
    case (op)
      OP_APPEND: begin
        if (len_sel < LEN_W'(MAX_ROUTE_LEN)) begin
          we      = 1'b1;
          wpos    = len_sel[POS_W-1:0];
          len_nxt = len_sel + 1'b1;
        end
      end
      OP_SET: begin
        if ({1'b0, req.pos} < len_sel) we = 1'b1;
      end
      OP_TRUNC: begin
        if ({1'b0, req.pos} < len_sel) len_nxt = {1'b0, req.pos};
      end
      default: ;
    endcase
    if (we && wpos == '0) head_nxt[req.idx] = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (we) mem[{req.idx, wpos}] <= req.src;
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n || op == OP_IDENT) begin
      head_r <= '0;
      for (int i = 0; i < OUT_PORTS; i++) len_r[i] <= LEN_W'(1);
    end else begin
      head_r         <= head_nxt;
      len_r[req.idx] <= len_nxt;
    end
  end

endmodule
`default_nettype wire

### sv/pcrp_datapath.sv
`default_nettype none
module pcrp_datapath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  pcrp_pkg::ctrl_t             ctrl,
  input  logic [3:0]                  in_output_index,
  input  logic [15:0]                 in_connected_mask,
  input  logic [4:0]                  in_channel_count,
  input  logic [3:0]                  in_position,
  input  logic [3:0]                  in_source,
  input  logic [pcrp_pkg::CH_W-1:0]   rd_data,
  input  logic [pcrp_pkg::LEN_W-1:0]  len_sel,
  input  logic                        head_valid,
  output pcrp_pkg::edit_t             req,
  output logic [pcrp_pkg::ADDR_W-1:0] rd_addr,
  output pcrp_pkg::stat_t             stat,
  pcrp_out_if.source                  out_if
);
  import pcrp_pkg::*;

  logic [OUT_W-1:0]       idx_r;
  logic [OUT_PORTS-1:0]   mask_r;
  logic [CNT_W-1:0]       real_r;
  logic [POS_W-1:0]       pos_r;
  logic [CH_W-1:0]        src_r;
  logic [CNT_W-1:0]       cur_r, cur_nxt;
  logic [CNT_W-1:0]       end_r, end_nxt;
  logic [POS_W-1:0]       cnt_r, cnt_nxt;
  logic                   out_valid_r, out_valid_nxt;
  res_t                   res_r, res_nxt;

  logic [CNT_W-1:0]       plan, c_start, c_end;
  logic [OUT_W-1:0]       nxt_j, prv_j;
  logic                   has_nxt, has_prv, c_empty;
  logic                   adv;
  logic [CH_W-1:0]        cust_src;

  assign req = '{idx: idx_r, pos: pos_r, src: src_r};
  assign adv = !out_valid_r || out_if.ready;

  // range planning for the dynamic and single modes
  always_comb begin
    plan = (real_r == '0 || real_r > CNT_W'(PLAN_CHANNELS)) ? CNT_W'(PLAN_CHANNELS) : real_r;
    nxt_j   = '0;
    has_nxt = 1'b0;
    for (int j = OUT_PORTS - 1; j >= 0; j--) begin
      if (j > int'(idx_r) && mask_r[j]) begin
        nxt_j   = OUT_W'(j);
        has_nxt = 1'b1;
      end
    end
    prv_j   = '0;
    has_prv = 1'b0;
    for (int j = 0; j < OUT_PORTS; j++) begin
      if (j < int'(idx_r) && mask_r[j]) begin
        prv_j   = OUT_W'(j);
        has_prv = 1'b1;
      end
    end
    c_start = {1'b0, idx_r};
    c_end   = {1'b0, idx_r} + 1'b1;
    c_empty = 1'b0;
    if (ctrl.mode == MODE_DYN_BELOW || ctrl.mode == MODE_DYN_ABOVE) begin
      if (ctrl.mode == MODE_DYN_BELOW) begin
        c_end   = (has_nxt && {1'b0, nxt_j} < plan) ? {1'b0, nxt_j} : plan;
        c_start = ({1'b0, idx_r} < plan) ? {1'b0, idx_r} : plan;
      end else begin
        c_start = has_prv ? {1'b0, prv_j} + 1'b1 : '0;
        if (c_start > plan) c_start = plan;
        c_end = {1'b0, idx_r} + 1'b1;
      end
      if (c_end < c_start) c_end = c_start;
      if (c_end > plan) c_end = plan;
      c_empty = !mask_r[idx_r] || (c_end <= c_start);
    end
  end

  assign cust_src = (cnt_r == '0 && !head_valid) ? CH_W'(idx_r) : rd_data;

  always_comb begin
    stat.adv      = adv;
    stat.empty    = c_empty;
    stat.len_zero = (len_sel == '0);
    case (ctrl.op)
      OP_EMIT_RANGE: stat.last = (cur_r + 1'b1 == end_r);
      OP_EMIT_CUST:  stat.last = ({1'b0, cnt_r} + 1'b1 == len_sel);
      default:       stat.last = 1'b1;
    endcase
  end

  always_comb begin
    rd_addr = {idx_r, cnt_r};
    if (ctrl.op == OP_CUST_START) rd_addr = {idx_r, {POS_W{1'b0}}};
    else if (ctrl.op == OP_EMIT_CUST && adv) rd_addr = {idx_r, cnt_r + 1'b1};
  end

  always_comb begin
    cur_nxt       = cur_r;
    end_nxt       = end_r;
    cnt_nxt       = cnt_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_if.ready;
    case (ctrl.op)
      OP_CALC: begin
        cur_nxt = c_start;
        end_nxt = c_end;
        cnt_nxt = '0;
      end
      OP_CUST_START: cnt_nxt = '0;
      OP_EMIT_RANGE: begin
        if (adv) begin
          out_valid_nxt          = 1'b1;
          res_nxt.dest_output    = idx_r;
          res_nxt.slot           = cnt_r;
          res_nxt.source_channel = cur_r[CH_W-1:0];
          res_nxt.silent         = (cur_r >= real_r);
          res_nxt.empty_res      = 1'b0;
          res_nxt.last           = stat.last;
          cur_nxt                = cur_r + 1'b1;
          cnt_nxt                = cnt_r + 1'b1;
        end
      end
      OP_EMIT_CUST: begin
        if (adv) begin
          out_valid_nxt          = 1'b1;
          res_nxt.dest_output    = idx_r;
          res_nxt.slot           = cnt_r;
          res_nxt.source_channel = cust_src;
          res_nxt.silent         = ({1'b0, cust_src} >= real_r);
          res_nxt.empty_res      = 1'b0;
          res_nxt.last           = stat.last;
          cnt_nxt                = cnt_r + 1'b1;
        end
      end
      OP_EMIT_EMPTY: begin
        if (adv) begin
          out_valid_nxt          = 1'b1;
          res_nxt.dest_output    = idx_r;
          res_nxt.slot           = '0;
          res_nxt.source_channel = '0;
          res_nxt.silent         = 1'b0;
          res_nxt.empty_res      = 1'b1;
          res_nxt.last           = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    end_r <= end_nxt;
    cnt_r <= cnt_nxt;
    res_r <= res_nxt;
    if (ctrl.accept) begin
      idx_r  <= in_output_index;
      mask_r <= in_connected_mask;
      real_r <= in_channel_count;
      pos_r  <= in_position;
      src_r  <= in_source;
    end
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.dest_output    = res_r.dest_output;
  assign out_if.slot           = res_r.slot;
  assign out_if.source_channel = res_r.source_channel;
  assign out_if.silent         = res_r.silent;
  assign out_if.empty_res      = res_r.empty_res;
  assign out_if.last           = res_r.last;

endmodule
`default_nettype wire
